@@ sv/signed_integer_radix_formatter_macros.svh @@
// Assertion helpers used by the checker.
`ifndef SIGNED_INTEGER_RADIX_FORMATTER_MACROS_SVH
`define SIGNED_INTEGER_RADIX_FORMATTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SIRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sirf assertion failed");

// Next-cycle implication, checked out of reset.
`define SIRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sirf assertion failed");

`endif

@@ sv/sirf_pkg.sv @@
`timescale 1ns / 1ps

package sirf_pkg;

  localparam int MAX_RADIX  = 16;
  localparam int MAX_DIGITS = 32;
  localparam int NUM_SYMS   = 16;
  localparam int WORD_W     = 32;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int RADIX_W    = 5;
  localparam int CFG_W      = 64;
  localparam int IDX_W      = 2;
  localparam int CNT_W      = 6;
  localparam int POS_W      = 5;
  localparam int STEP_BITS  = 8;
  localparam int PHASES     = WORD_W / STEP_BITS;
  localparam int PHASE_W    = 2;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  localparam logic [IDX_W-1:0] REG_RADIX        = 2'd0;
  localparam logic [IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } sirf_state_t;

endpackage

@@ sv/signed_integer_radix_formatter.sv @@
`timescale 1ns / 1ps
// Signed integer radix formatter.
// Load radix and the sixteen digit symbols through the cfg_ write port while
// the block is idle (cfg_index 0 radix, 1 symbols 0..7, 2 symbols 8..15).
// A number is taken at a clock edge with start high and busy low. Its text
// leaves on out_character, one byte per cycle, each marked by out_valid;
// out_last flags the final byte. A negative number gives '-' first.
// An invalid base (radix below 2 or above 16, a sign among the symbols in
// use, or two equal symbols in use) produces no beats at all.
// The base is checked first, then a long division by the radix
// retires 8 dividend bits per cycle in a shared unit of eight 5-bit steps,
// so a digit is done once the whole 32-bit quotient has passed through.
// The first byte shows once every digit is stored, and the bytes then
// stream back to back. busy stays high through the last beat and drops
// the cycle after, so a new number is taken only once the whole text,
// and its minus sign if any, has left.
// An invalid base returns the block to idle straight after the check.
// The receiver cannot stall; every beat is valid for exactly one cycle.
// Reset (synchronous, rst_n low) zeroes out_valid, radix and the symbols and
// returns the sequencer to idle; the digit store and datapath are not reset.
module signed_integer_radix_formatter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [sirf_pkg::WORD_W-1:0] in_number,
  output logic                               out_valid,
  output logic [sirf_pkg::CHAR_W-1:0]        out_character,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [sirf_pkg::IDX_W-1:0]         cfg_index,
  input  logic [sirf_pkg::CFG_W-1:0]         cfg_wdata
);

  sirf_pkg::sirf_state_t state_r, state_nxt;

  logic [sirf_pkg::RADIX_W-1:0] radix_r;
  logic [sirf_pkg::CFG_W-1:0]   sym_lo_r;
  logic [sirf_pkg::CFG_W-1:0]   sym_hi_r;

  logic                         neg_r, neg_nxt;
  logic [sirf_pkg::WORD_W-1:0]  quo_r, quo_nxt;
  logic [sirf_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [sirf_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [sirf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [sirf_pkg::DIGIT_W-1:0] dig_r [sirf_pkg::MAX_DIGITS];
  logic                         dig_we;

  logic                         out_valid_r, out_valid_nxt;
  logic [sirf_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [2*sirf_pkg::CFG_W-1:0] sym_all;
  logic                         base_ok;
  logic [sirf_pkg::WORD_W-1:0]  quo_step;
  logic [sirf_pkg::DIGIT_W-1:0] rem_step;
  logic [sirf_pkg::CNT_W-1:0]   emit_pos;
  logic [sirf_pkg::DIGIT_W-1:0] emit_dig;

  assign sym_all  = {sym_hi_r, sym_lo_r};
  assign emit_pos = cnt_r - sirf_pkg::CNT_W'(1);
  assign emit_dig = dig_r[emit_pos[sirf_pkg::POS_W-1:0]];

  // Base check: radix range, and every symbol in use against the signs and pairwise, in parallel.
  always_comb begin
    logic bad;
    bad = (radix_r < sirf_pkg::RADIX_W'(2)) ||
          (radix_r > sirf_pkg::RADIX_W'(sirf_pkg::MAX_RADIX));
    for (int i = 0; i < sirf_pkg::NUM_SYMS; i++) begin
      if (sirf_pkg::RADIX_W'(i) < radix_r) begin
        if ((sym_all[8*i +: 8] == sirf_pkg::CHAR_PLUS) ||
            (sym_all[8*i +: 8] == sirf_pkg::CHAR_MINUS)) begin
          bad = 1'b1;
        end
      end
      for (int j = i + 1; j < sirf_pkg::NUM_SYMS; j++) begin
        if ((sirf_pkg::RADIX_W'(j) < radix_r) &&
            (sym_all[8*i +: 8] == sym_all[8*j +: 8])) begin
          bad = 1'b1;
        end
      end
    end
    base_ok = !bad;
  end

  // Shared divide unit: eight restoring steps on a 5-bit partial remainder.
  always_comb begin
    logic [sirf_pkg::RADIX_W-1:0] t;
    logic [sirf_pkg::WORD_W-1:0]  q;
    logic [sirf_pkg::DIGIT_W-1:0] r;
    q = quo_r;
    r = rem_r;
    for (int k = 0; k < sirf_pkg::STEP_BITS; k++) begin
      t = {r, q[sirf_pkg::WORD_W-1]};
      q = {q[sirf_pkg::WORD_W-2:0], 1'b0};
      if (t >= radix_r) begin
        t    = t - radix_r;
        q[0] = 1'b1;
      end
      r = t[sirf_pkg::DIGIT_W-1:0];
    end
    quo_step = q;
    rem_step = r;
  end

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    dig_we        = 1'b0;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      sirf_pkg::ST_IDLE: begin
        // hold off while the last beat of the previous text is out
        if (start && !busy) begin
          neg_nxt   = in_number[sirf_pkg::WORD_W-1];
          quo_nxt   = in_number[sirf_pkg::WORD_W-1] ?
                      (~in_number + sirf_pkg::WORD_W'(1)) : in_number;
          state_nxt = sirf_pkg::ST_CHECK;
        end
      end
      sirf_pkg::ST_CHECK: begin
        rem_nxt   = '0;
        phase_nxt = '0;
        cnt_nxt   = '0;
        state_nxt = base_ok ? sirf_pkg::ST_DIVIDE : sirf_pkg::ST_IDLE;
      end
      sirf_pkg::ST_DIVIDE: begin
        quo_nxt   = quo_step;
        rem_nxt   = rem_step;
        phase_nxt = phase_r + sirf_pkg::PHASE_W'(1);
        if (phase_r == sirf_pkg::PHASE_W'(sirf_pkg::PHASES - 1)) begin
          // Digit done: store it, restart on the quotient or drain.
          dig_we  = 1'b1;
          cnt_nxt = cnt_r + sirf_pkg::CNT_W'(1);
          rem_nxt = '0;
          if (quo_step == '0) begin
            state_nxt = neg_r ? sirf_pkg::ST_SIGN : sirf_pkg::ST_EMIT;
          end
        end
      end
      sirf_pkg::ST_SIGN: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = sirf_pkg::CHAR_MINUS;
        out_last_nxt  = 1'b0;
        state_nxt     = sirf_pkg::ST_EMIT;
      end
      sirf_pkg::ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = sym_all[{emit_dig, 3'b000} +: 8];
        out_last_nxt  = (emit_pos == '0);
        cnt_nxt       = emit_pos;
        if (emit_pos == '0) begin
          state_nxt = sirf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sirf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sirf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      radix_r     <= '0;
      sym_lo_r    <= '0;
      sym_hi_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          sirf_pkg::REG_RADIX:        radix_r  <= cfg_wdata[sirf_pkg::RADIX_W-1:0];
          sirf_pkg::REG_SYMBOLS_LOW:  sym_lo_r <= cfg_wdata;
          sirf_pkg::REG_SYMBOLS_HIGH: sym_hi_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    phase_r    <= phase_nxt;
    cnt_r      <= cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (dig_we) begin
      dig_r[cnt_r[sirf_pkg::POS_W-1:0]] <= rem_step;
    end
  end

  assign busy          = (state_r != sirf_pkg::ST_IDLE) || out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

@@ sv/sirf_checker.sv @@
`timescale 1ns / 1ps
`include "signed_integer_radix_formatter_macros.svh"

module sirf_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic signed [sirf_pkg::WORD_W-1:0] in_number,
  input logic                               out_valid,
  input logic [sirf_pkg::CHAR_W-1:0]        out_character,
  input logic                               out_last,
  input logic                               cfg_we,
  input logic [sirf_pkg::IDX_W-1:0]         cfg_index,
  input logic [sirf_pkg::CFG_W-1:0]         cfg_wdata
);

  // A beat only shows while a number is in flight.
  `SIRF_ASSERT_NOW(a_beat_while_busy, clk, rst_n, out_valid, busy)
  // An accepted number holds off the next one.
  `SIRF_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // The text streams without gaps up to its last byte.
  `SIRF_ASSERT_NXT(a_run_gapless, clk, rst_n, out_valid && !out_last, out_valid)
  // After the last byte the run ends and the block frees up.
  `SIRF_ASSERT_NXT(a_run_ends, clk, rst_n, out_valid && out_last, !out_valid && !busy)
  // A minus sign never closes a run.
  `SIRF_ASSERT_NOW(a_sign_not_last, clk, rst_n,
    out_valid && out_last, out_character != sirf_pkg::CHAR_MINUS)

endmodule

bind signed_integer_radix_formatter sirf_checker u_sirf_checker (.*);
